// File: rtl/htw_pkg.sv
package htw_pkg;
  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_ZERO     = 2'd2;
  localparam logic [1:0] KIND_EXPIRED  = 2'd3;
  localparam logic       ACTION_ADD    = 1'b0;
  localparam logic       ACTION_TICK   = 1'b1;
endpackage

// File: rtl/htw_ram.sv
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hierarchical_timer_wheel.sv
// Two-level timer wheel with an overflow list. Each slave beat either adds a timer
// (one result beat: accepted, pool full, or zero delay) or advances time by one tick
// (one result beat per expiring task, in FIFO order, tlast on the final one, none if
// nothing expires). Timer entries and the per-slot list heads and tails sit in
// synchronous RAMs with registered reads, and the linked lists are walked serially
// through one read port, which sets the timing. A zero-delay or pool-full add puts its
// result out the cycle after the beat; an accepted add first files the timer (slot
// read, tail entry read, link write, entry write). A new beat is taken only once the
// result is gone. A tick reads and empties the next level-one slot and puts out each
// expired timer in turn; at a block end it first cascades a level-two slot down into
// level one, and at a round end it walks the overflow list before that, keeping each
// timer or moving it down to level two. A stall on the result side holds back the next
// beat and the expiry walk. After reset a clearing pass over the slots of both levels
// marks all slot lists empty before the first beat is accepted.
module hierarchical_timer_wheel #(
  parameter int LEVEL1_SLOTS = 256,
  parameter int LEVEL2_SLOTS = 64,
  parameter int MAX_TIMERS   = 64,
  parameter int TASK_ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // task_id[15:0], delay[47:16]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // expired_task[15:0]
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);
  import htw_pkg::*;

  localparam int L1B = (LEVEL1_SLOTS > 1) ? $clog2(LEVEL1_SLOTS) : 1;
  localparam int L2B = (LEVEL2_SLOTS > 1) ? $clog2(LEVEL2_SLOTS) : 1;
  localparam int PB  = L1B + L2B;
  localparam int EB  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int PTR = EB + 1;
  localparam int XB  = 33;
  localparam int LW  = 2 * PTR;
  localparam int CLRN = (LEVEL1_SLOTS > LEVEL2_SLOTS) ? LEVEL1_SLOTS : LEVEL2_SLOTS;
  localparam int CB  = $clog2(CLRN + 1);
  localparam logic [PTR-1:0] NIL = {1'b1, {EB{1'b0}}};
  localparam int EW  = TASK_ID_BITS + XB + PTR;
  localparam logic [XB-1:0] ROUND = XB'(LEVEL1_SLOTS) * XB'(LEVEL2_SLOTS);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_ADD = 5'd2, S_PUSH_RD = 5'd3,
    S_PUSH_WT = 5'd4, S_PUSH_DO = 5'd5, S_RESP = 5'd6, S_OV_RD = 5'd7, S_OV_DO = 5'd8,
    S_CA_RD = 5'd9, S_CA_WT = 5'd10, S_CA_EN = 5'd11, S_CA_DO = 5'd12, S_EX_RD = 5'd13,
    S_EX_WT = 5'd14, S_EX_EN = 5'd15, S_EX_DO = 5'd16, S_OUT = 5'd17, S_OV_WT = 5'd18,
    S_CA_EW = 5'd19;

  // Push target kinds.
  localparam logic [1:0] TGT_L1 = 2'd0, TGT_L2 = 2'd1, TGT_OV = 2'd2;
  // What to do after a push completes.
  localparam logic [1:0] RET_ADD = 2'd0, RET_OV = 2'd1, RET_CA = 2'd2;

  logic [4:0] state;
  logic [CB-1:0] clr_cnt;
  logic [PB-1:0] pos;
  logic [MAX_TIMERS-1:0] in_use;
  logic [PTR-1:0] ov_head, ov_tail;

  // Entry RAM: {task, expiry, next}.
  logic e_we; logic [EB-1:0] e_wa, e_ra; logic [EW-1:0] e_wd, e_rd;
  htw_ram #(.WIDTH(EW), .DEPTH(MAX_TIMERS)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  logic l1_we; logic [L1B-1:0] l1_wa, l1_ra; logic [LW-1:0] l1_wd, l1_rd;
  htw_ram #(.WIDTH(LW), .DEPTH(LEVEL1_SLOTS)) u_l1 (
    .clk(clk), .we(l1_we), .waddr(l1_wa), .wdata(l1_wd), .raddr(l1_ra), .rdata(l1_rd));
  logic l2_we; logic [L2B-1:0] l2_wa, l2_ra; logic [LW-1:0] l2_wd, l2_rd;
  htw_ram #(.WIDTH(LW), .DEPTH(LEVEL2_SLOTS)) u_l2 (
    .clk(clk), .we(l2_we), .waddr(l2_wa), .wdata(l2_wd), .raddr(l2_ra), .rdata(l2_rd));

  // Working registers.
  logic [TASK_ID_BITS-1:0] r_task;
  logic [EB-1:0] r_e;        // entry being pushed
  logic [XB-1:0] r_exp;      // its expiry
  logic [1:0] r_tgt, r_ret;
  logic [L2B-1:0] r_slot2;
  logic [L1B-1:0] r_slot1;
  logic [PTR-1:0] r_cur, r_prev, r_nxt;
  logic r_tick_ca;           // block end pending after overflow walk
  logic [1:0] o_kind; logic [15:0] o_task; logic o_last; logic o_valid;

  // Free entry search: lowest zero of in_use.
  logic [EB-1:0] free_e; logic free_ok;
  always_comb begin
    free_e = '0; free_ok = 1'b0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_e = EB'(i); free_ok = 1'b1;
      end
    end
  end

  logic [15:0] in_task; logic [31:0] in_delay; logic [XB-1:0] add_exp;
  assign in_task  = s_tdata[15:0];
  assign in_delay = s_tdata[47:16];
  assign add_exp  = XB'(pos) + XB'(in_delay);

  logic [TASK_ID_BITS-1:0] e_task; logic [XB-1:0] e_exp; logic [PTR-1:0] e_next;
  assign {e_task, e_exp, e_next} = e_rd;
  logic [XB-1:0] ov_exp;
  assign ov_exp = (e_exp >= ROUND) ? e_exp - ROUND : '0;

  logic [PTR-1:0] tgt_head, tgt_tail;
  always_comb begin
    case (r_tgt)
      TGT_L1:  {tgt_head, tgt_tail} = l1_rd;
      TGT_L2:  {tgt_head, tgt_tail} = l2_rd;
      default: {tgt_head, tgt_tail} = {ov_head, ov_tail};
    endcase
  end

  logic round_end, block_end;
  assign round_end = (pos == PB'(ROUND - 1));
  assign block_end = (pos[L1B-1:0] == L1B'(LEVEL1_SLOTS - 1));
  logic [PB-1:0] pos_inc;
  assign pos_inc = (pos == PB'(ROUND - 1)) ? '0 : pos + 1'b1;

  assign s_tready = (state == S_IDLE) && !o_valid;
  assign m_tvalid = o_valid;
  assign m_tdata  = o_task;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;

  // Memory port drive.
  always_comb begin
    e_we = 1'b0; e_wa = r_e; e_wd = '0; e_ra = r_cur[EB-1:0];
    l1_we = 1'b0; l1_wa = r_slot1; l1_wd = '0; l1_ra = r_slot1;
    l2_we = 1'b0; l2_wa = r_slot2; l2_wd = '0; l2_ra = r_slot2;
    case (state)
      S_CLR: begin
        l1_we = (clr_cnt < CB'(LEVEL1_SLOTS)); l1_wa = L1B'(clr_cnt); l1_wd = {NIL, NIL};
        l2_we = (clr_cnt < CB'(LEVEL2_SLOTS)); l2_wa = L2B'(clr_cnt); l2_wd = {NIL, NIL};
      end
      S_PUSH_DO: begin
        // Write new tail entry fully, or old tail's link.
        if (tgt_head[PTR-1] || tgt_tail[PTR-1]) begin
          e_we = 1'b1; e_wa = r_e; e_wd = {r_task, r_exp, NIL};
        end else begin
          e_we = 1'b1; e_wa = tgt_tail[EB-1:0];
          e_wd = {e_task, e_exp, PTR'(r_e)};
        end
        if (r_tgt == TGT_L1) begin
          l1_we = 1'b1;
          l1_wd = (tgt_head[PTR-1] || tgt_tail[PTR-1]) ? {PTR'(r_e), PTR'(r_e)}
                                                       : {tgt_head, PTR'(r_e)};
        end else if (r_tgt == TGT_L2) begin
          l2_we = 1'b1;
          l2_wd = (tgt_head[PTR-1] || tgt_tail[PTR-1]) ? {PTR'(r_e), PTR'(r_e)}
                                                       : {tgt_head, PTR'(r_e)};
        end
      end
      S_RESP: begin
        // Second write for the linked-tail case: store the new entry itself.
        e_we = 1'b1; e_wa = r_e; e_wd = {r_task, r_exp, NIL};
      end
      S_OV_DO: begin
        // Store lowered expiry, and fetch the previous entry for a possible unlink.
        e_we = 1'b1; e_wa = r_cur[EB-1:0]; e_wd = {e_task, ov_exp, e_next};
        e_ra = r_prev[EB-1:0];
      end
      S_OV_WT: begin
        e_we = !r_prev[PTR-1]; e_wa = r_prev[EB-1:0];
        e_wd = {e_task, e_exp, r_nxt};
      end
      S_CA_RD: l2_ra = r_slot2;
      S_CA_EN: begin
        l2_we = 1'b1; l2_wd = {NIL, NIL};
      end
      S_EX_RD: l1_ra = r_slot1;
      S_EX_EN: begin
        l1_we = 1'b1; l1_wd = {NIL, NIL};
      end
      S_EX_DO: begin
        e_we = 1'b1; e_wa = r_cur[EB-1:0]; e_wd = {e_task, e_exp, NIL};
      end
      default: ;
    endcase
    // Push reads the old tail entry so its contents survive the link write.
    if (state == S_PUSH_RD) begin
      l1_ra = r_slot1; l2_ra = r_slot2;
    end
    if (state == S_PUSH_WT) e_ra = tgt_tail[EB-1:0];
  end

  // The push reads the tail entry in the cycle after the slot read; S_PUSH_WT issues it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; pos <= '0; in_use <= '0;
      ov_head <= NIL; ov_tail <= NIL; o_valid <= 1'b0;
    end else begin
      if (o_valid && m_tready && state != S_EX_DO) o_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CB'(CLRN - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          r_task <= TASK_ID_BITS'(in_task);
          if (s_tuser == ACTION_ADD) begin
            o_task <= 16'(TASK_ID_BITS'(in_task)); o_last <= 1'b1;
            if (in_delay == 32'd0) begin
              o_kind <= KIND_ZERO; o_valid <= 1'b1;
            end else if (!free_ok) begin
              o_kind <= KIND_FULL; o_valid <= 1'b1;
            end else begin
              o_kind <= KIND_ADD_OK;
              r_e <= free_e; r_exp <= add_exp; r_ret <= RET_ADD;
              in_use[free_e] <= 1'b1;
              r_slot1 <= add_exp[L1B-1:0];
              r_slot2 <= L2B'(add_exp[XB-1:L1B]);
              if (in_delay < 32'(LEVEL1_SLOTS)) r_tgt <= TGT_L1;
              else if (XB'(in_delay) < ROUND) r_tgt <= TGT_L2;
              else r_tgt <= TGT_OV;
              state <= S_PUSH_RD;
            end
          end else begin
            r_tick_ca <= block_end;
            r_slot2 <= L2B'(pos_inc[PB-1:L1B]);
            r_slot1 <= pos_inc[L1B-1:0];
            if (round_end) begin
              r_cur <= ov_head; r_prev <= NIL; state <= S_OV_RD;
            end else if (block_end) state <= S_CA_RD;
            else state <= S_EX_RD;
          end
        end
        S_PUSH_RD: state <= S_PUSH_WT;   // slot head/tail arriving
        S_PUSH_WT: state <= S_PUSH_DO;   // tail entry arriving
        S_PUSH_DO: begin
          if (r_tgt == TGT_OV) begin
            if (tgt_head[PTR-1] || tgt_tail[PTR-1]) ov_head <= PTR'(r_e);
            ov_tail <= PTR'(r_e);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          case (r_ret)
            RET_ADD: begin
              o_valid <= 1'b1; state <= S_IDLE;
            end
            RET_OV: begin
              r_cur <= r_nxt; state <= S_OV_RD;
            end
            default: begin
              r_cur <= r_nxt; state <= S_CA_EW;
            end
          endcase
        end
        // Overflow walk at the round end.
        S_OV_RD: begin
          if (r_cur[PTR-1]) begin
            if (ov_head[PTR-1]) ov_tail <= NIL;
            // The walk reused the level-two slot register; restore the cascade slot.
            r_slot2 <= L2B'(pos_inc[PB-1:L1B]);
            state <= r_tick_ca ? S_CA_RD : S_EX_RD;
          end else state <= S_OV_DO;
        end
        S_OV_DO: begin
          r_nxt <= e_next;
          if (ov_exp < ROUND) begin
            r_e <= r_cur[EB-1:0]; r_exp <= ov_exp; r_task <= e_task;
            r_slot2 <= L2B'(ov_exp[XB-1:L1B]); r_tgt <= TGT_L2; r_ret <= RET_OV;
            if (r_prev[PTR-1]) ov_head <= e_next;
            if (ov_tail == r_cur) ov_tail <= r_prev;
            state <= S_OV_WT;
          end else begin
            r_prev <= r_cur; r_cur <= e_next; state <= S_OV_RD;
          end
        end
        S_OV_WT: state <= S_PUSH_RD;   // prev link rewritten, go push
        // Cascade one level-two slot.
        S_CA_RD: state <= S_CA_WT;
        S_CA_WT: begin
          r_cur <= l2_rd[LW-1:PTR]; state <= S_CA_EN;
        end
        S_CA_EN: state <= S_CA_EW;
        S_CA_EW: begin
          if (r_cur[PTR-1]) begin
            r_slot1 <= pos_inc[L1B-1:0]; state <= S_EX_RD;
          end else state <= S_CA_DO;
        end
        S_CA_DO: begin
          r_nxt <= e_next; r_e <= r_cur[EB-1:0]; r_exp <= e_exp; r_task <= e_task;
          r_slot1 <= e_exp[L1B-1:0]; r_tgt <= TGT_L1; r_ret <= RET_CA;
          state <= S_PUSH_RD;
        end
        // Expire the current level-one slot.
        S_EX_RD: begin
          pos <= pos_inc; state <= S_EX_WT;
        end
        S_EX_WT: begin
          r_cur <= l1_rd[LW-1:PTR]; state <= S_EX_EN;
        end
        S_EX_EN: begin
          if (r_cur[PTR-1]) state <= S_IDLE;
          else state <= S_EX_DO;
        end
        S_EX_DO: if (!o_valid || m_tready) begin
          o_valid <= 1'b1; o_kind <= KIND_EXPIRED;
          o_task <= 16'(e_task); o_last <= e_next[PTR-1];
          in_use[r_cur[EB-1:0]] <= 1'b0;
          r_cur <= e_next;
          state <= e_next[PTR-1] ? S_IDLE : S_OUT;
        end
        S_OUT: state <= S_EX_DO;   // read next entry
        default: state <= S_IDLE;
      endcase
    end
  end

  // No new beat is taken while a result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    o_valid && !m_tready |-> !s_tready) else $error("accept while result pending");
  // Input is taken only in the idle state.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && !m_tready) && !$past(rst) |-> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
endmodule
